// ===== rtl/mts_pkg.sv =====
package mts_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int NUM_PROD    = 12;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [8:0][WORD_W-1:0] mat_t;
  typedef logic [LVL_W-1:0] lvl_t;

  typedef enum logic [4:0] {
    OP_INIT      = 5'd0,
    OP_PUSH      = 5'd1,
    OP_POP       = 5'd2,
    OP_IDENTITY  = 5'd3,
    OP_TRANSLATE = 5'd4,
    OP_MIRROR_Y  = 5'd5,
    OP_MIRROR_X  = 5'd6,
    OP_ROTATE    = 5'd7,
    OP_PREMULT   = 5'd8,
    OP_POINT     = 5'd9,
    OP_INVERSE   = 5'd10,
    OP_INV_POINT = 5'd11,
    OP_SAVE      = 5'd12,
    OP_RESTORE   = 5'd13,
    OP_LOAD_INV  = 5'd14,
    OP_READ      = 5'd15,
    OP_WRITE     = 5'd16
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2
  } err_t;

  function automatic mat_t ident();
    mat_t m;
    m    = '0;
    m[0] = word_t'(1);
    m[4] = word_t'(1);
    m[8] = word_t'(1);
    return m;
  endfunction

endpackage

// ===== rtl/mts_row_ram.sv =====
module mts_row_ram #(
  parameter int WIDTH = 288,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/manhattan_transform_stack.sv =====
// stack of 3x3 integer manhattan transform matrices driven by a command stream
// input channel: one word per command, opcode on in_tuser, operands on in_tdata
// output channel: exactly one result word per command, in command order
// each stack row (nine elements) lives in one word of a row-wide ram with a
// registered read; commands on the top row read it, and those that modify it
// write it back; premultiply also reads the row below it first
// init, push, pop, errors and unused opcodes go straight to execute; inv_point
// passes through the multiply state first; commands on the top row pass through
// read, wait and multiply states, and premultiply reads the row below before
// those; one command is in flight at a time, so none is taken until it executes
// the products of point, inv_point, premultiply and inverse are taken in one
// registered multiplier stage, and the sums and write-back in the next
// reset empties the stack and clears the saved and inverse matrices; ram
// contents are not cleared, since init and push always write a fresh row
// when out_tready is low the result is held and the block waits before
// retiring the command; a new command is not taken until then
module manhattan_transform_stack (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // x_value, y_value, element_index
  input  logic [4:0]   in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // x_result, y_result, element_value,
                                   // stack_empty, stack_full, error_code
);

  import mts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RDN, S_RDT, S_WAIT, S_MUL, S_EXEC
  } state_t;

  state_t state_r;
  logic [4:0] op_r;
  word_t x_r, y_r;
  logic [3:0] idx_r;
  err_t err_r;
  lvl_t level_r;
  mat_t saved_r, inv_r, n_r;
  word_t prod_r [NUM_PROD];
  logic out_tvalid_r;
  word_t out_x_r, out_y_r, out_elem_r;
  logic out_empty_r, out_full_r;
  err_t out_err_r;

  mat_t rd_data;
  logic mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  mat_t mem_wdata;

  lvl_t lvl_m1, lvl_m2;
  logic [4:0] in_op;
  logic in_fire, uses_top, top_err;
  logic exec_go;

  assign lvl_m1 = level_r - lvl_t'(1);
  assign lvl_m2 = level_r - lvl_t'(2);
  assign in_op = in_tuser;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid && in_tready;
  assign uses_top = (in_op >= 5'(OP_POP)) && (in_op <= 5'(OP_WRITE)) &&
                    (in_op != 5'(OP_INV_POINT));
  assign top_err = (level_r == '0) ||
                   ((in_op == 5'(OP_PREMULT)) && (level_r < lvl_t'(2)));
  assign exec_go = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);

  mts_row_ram #(
    .WIDTH ($bits(mat_t)),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign mem_re = (state_r == S_RDN) || (state_r == S_RDT);
  assign mem_raddr = (state_r == S_RDN) ? lvl_m2[ADDR_W-1:0] : lvl_m1[ADDR_W-1:0];

  // multiplier operands
  mat_t src;
  word_t opa [NUM_PROD];
  word_t opb [NUM_PROD];

  assign src = (op_r == 5'(OP_INV_POINT)) ? inv_r : rd_data;

  always_comb begin
    for (int k = 0; k < NUM_PROD; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    unique case (op_r)
      5'(OP_POINT), 5'(OP_INV_POINT): begin
        opa[0] = x_r; opb[0] = src[0];
        opa[1] = y_r; opb[1] = src[3];
        opa[2] = x_r; opb[2] = src[1];
        opa[3] = y_r; opb[3] = src[4];
      end
      5'(OP_PREMULT): begin
        for (int i = 0; i < 3; i++) begin
          opa[4*i]   = rd_data[3*i];   opb[4*i]   = n_r[0];
          opa[4*i+1] = rd_data[3*i+1]; opb[4*i+1] = n_r[3];
          opa[4*i+2] = rd_data[3*i];   opb[4*i+2] = n_r[1];
          opa[4*i+3] = rd_data[3*i+1]; opb[4*i+3] = n_r[4];
        end
      end
      5'(OP_INVERSE): begin
        opa[0] = rd_data[0]; opb[0] = rd_data[4];
        opa[1] = rd_data[3]; opb[1] = rd_data[1];
        opa[2] = rd_data[3]; opb[2] = rd_data[7];
        opa[3] = rd_data[6]; opb[3] = rd_data[4];
        opa[4] = rd_data[1]; opb[4] = rd_data[6];
        opa[5] = rd_data[0]; opb[5] = rd_data[7];
      end
      default: begin
      end
    endcase
  end

  // execute stage
  mat_t row_nxt, inv_nxt, saved_nxt;
  lvl_t level_nxt;
  logic wr_row;
  logic [ADDR_W-1:0] wr_addr;
  word_t x_nxt, y_nxt, elem_nxt;
  word_t det, t0, t1;
  logic xz, yz, rot_cw, rot_ccw, rot_half;
  word_t tmp;

  assign det = prod_r[0] - prod_r[1];
  assign t0  = prod_r[2] - prod_r[3];
  assign t1  = prod_r[4] - prod_r[5];
  assign xz = (x_r == '0);
  assign yz = (y_r == '0);
  assign rot_cw   = xz && !yz && y_r[WORD_W-1];
  assign rot_ccw  = xz && !yz && !y_r[WORD_W-1];
  assign rot_half = yz && !xz && x_r[WORD_W-1];

  always_comb begin
    row_nxt   = rd_data;
    inv_nxt   = inv_r;
    saved_nxt = saved_r;
    level_nxt = level_r;
    wr_row    = 1'b0;
    wr_addr   = lvl_m1[ADDR_W-1:0];
    x_nxt     = '0;
    y_nxt     = '0;
    elem_nxt  = '0;
    tmp       = '0;
    if (err_r == ERR_NONE) begin
      unique case (op_r)
        5'(OP_INIT): begin
          level_nxt = lvl_t'(1);
          row_nxt   = ident();
          wr_row    = 1'b1;
          wr_addr   = '0;
        end
        5'(OP_PUSH): begin
          level_nxt = level_r + lvl_t'(1);
          row_nxt   = ident();
          wr_row    = 1'b1;
          wr_addr   = level_r[ADDR_W-1:0];
        end
        5'(OP_POP): level_nxt = lvl_m1;
        5'(OP_IDENTITY): begin
          row_nxt = ident();
          wr_row  = 1'b1;
        end
        5'(OP_TRANSLATE): begin
          row_nxt[6] = rd_data[6] + x_r;
          row_nxt[7] = rd_data[7] + y_r;
          wr_row     = 1'b1;
        end
        5'(OP_MIRROR_Y): begin
          row_nxt[1] = -rd_data[1];
          row_nxt[4] = -rd_data[4];
          row_nxt[7] = -rd_data[7];
          wr_row     = 1'b1;
        end
        5'(OP_MIRROR_X): begin
          row_nxt[0] = -rd_data[0];
          row_nxt[3] = -rd_data[3];
          row_nxt[6] = -rd_data[6];
          wr_row     = 1'b1;
        end
        5'(OP_ROTATE): begin
          for (int r = 0; r < 3; r++) begin
            tmp = rd_data[3*r];
            if (rot_cw) begin
              row_nxt[3*r]   = rd_data[3*r+1];
              row_nxt[3*r+1] = -tmp;
            end else if (rot_ccw) begin
              row_nxt[3*r]   = -rd_data[3*r+1];
              row_nxt[3*r+1] = tmp;
            end else if (rot_half) begin
              row_nxt[3*r]   = -tmp;
              row_nxt[3*r+1] = -rd_data[3*r+1];
            end
          end
          wr_row = 1'b1;
        end
        5'(OP_PREMULT): begin
          for (int i = 0; i < 3; i++) begin
            row_nxt[3*i]   = prod_r[4*i] + prod_r[4*i+1] + ((i == 2) ? n_r[6] : '0);
            row_nxt[3*i+1] = prod_r[4*i+2] + prod_r[4*i+3] + ((i == 2) ? n_r[7] : '0);
          end
          wr_row = 1'b1;
        end
        5'(OP_POINT): begin
          x_nxt = prod_r[0] + prod_r[1] + rd_data[6];
          y_nxt = prod_r[2] + prod_r[3] + rd_data[7];
        end
        5'(OP_INV_POINT): begin
          x_nxt = prod_r[0] + prod_r[1] + inv_r[6];
          y_nxt = prod_r[2] + prod_r[3] + inv_r[7];
        end
        5'(OP_INVERSE): begin
          if (det == word_t'(1)) begin
            inv_nxt[0] = rd_data[4];
            inv_nxt[1] = -rd_data[1];
            inv_nxt[3] = -rd_data[3];
            inv_nxt[4] = rd_data[0];
            inv_nxt[6] = t0;
            inv_nxt[7] = t1;
          end else begin
            inv_nxt[0] = -rd_data[4];
            inv_nxt[1] = rd_data[1];
            inv_nxt[3] = rd_data[3];
            inv_nxt[4] = -rd_data[0];
            inv_nxt[6] = -t0;
            inv_nxt[7] = -t1;
          end
          inv_nxt[2] = '0;
          inv_nxt[5] = '0;
          inv_nxt[8] = word_t'(1);
        end
        5'(OP_SAVE): saved_nxt = rd_data;
        5'(OP_RESTORE): begin
          row_nxt = saved_r;
          wr_row  = 1'b1;
        end
        5'(OP_LOAD_INV): begin
          row_nxt = inv_r;
          wr_row  = 1'b1;
        end
        5'(OP_READ): begin
          if (idx_r < 4'd9) begin
            elem_nxt = rd_data[idx_r];
          end
        end
        5'(OP_WRITE): begin
          if (idx_r < 4'd9) begin
            row_nxt[idx_r] = x_r;
            wr_row         = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_we    = exec_go && wr_row;
  assign mem_waddr = wr_addr;
  assign mem_wdata = row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      level_r      <= '0;
      saved_r      <= '0;
      inv_r        <= '0;
      out_tvalid_r <= 1'b0;
      err_r        <= ERR_NONE;
    end else begin
      if (out_tvalid_r && out_tready && !exec_go) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r  <= in_op;
            x_r   <= in_tdata[31:0];
            y_r   <= in_tdata[63:32];
            idx_r <= in_tdata[67:64];
            err_r <= ERR_NONE;
            if (in_op == 5'(OP_PUSH) && level_r >= lvl_t'(STACK_DEPTH)) begin
              err_r   <= ERR_OVERFLOW;
              state_r <= S_EXEC;
            end else if (uses_top && top_err) begin
              err_r   <= ERR_UNDERFLOW;
              state_r <= S_EXEC;
            end else if (in_op == 5'(OP_INV_POINT)) begin
              state_r <= S_MUL;
            end else if (in_op == 5'(OP_PREMULT)) begin
              state_r <= S_RDN;
            end else if (uses_top && in_op != 5'(OP_POP)) begin
              state_r <= S_RDT;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_RDN: state_r <= S_RDT;
        S_RDT: begin
          if (op_r == 5'(OP_PREMULT)) begin
            n_r <= rd_data;
          end
          state_r <= S_WAIT;
        end
        S_WAIT: state_r <= S_MUL;
        S_MUL: begin
          for (int k = 0; k < NUM_PROD; k++) begin
            prod_r[k] <= opa[k] * opb[k];
          end
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            level_r      <= level_nxt;
            inv_r        <= inv_nxt;
            saved_r      <= saved_nxt;
            out_tvalid_r <= 1'b1;
            out_x_r      <= x_nxt;
            out_y_r      <= y_nxt;
            out_elem_r   <= elem_nxt;
            out_empty_r  <= (level_nxt == '0);
            out_full_r   <= (level_nxt >= lvl_t'(STACK_DEPTH));
            out_err_r    <= err_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_err_r, out_full_r, out_empty_r,
                       out_elem_r, out_y_r, out_x_r};

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= lvl_t'(STACK_DEPTH))
    else $error("stack level out of range");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EXEC) && (err_r == ERR_NONE))
    else $error("row write outside execute");

  a_err_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && (err_r != ERR_NONE) |=> level_r == $past(level_r))
    else $error("failed command changed the level");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |=> !$past(exec_go))
    else $error("pending result overwritten");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_empty_r && out_full_r))
    else $error("stack flagged both empty and full");

endmodule

// ===== test/tb_manhattan_transform_stack.sv =====
module tb_manhattan_transform_stack;
  import mts_pkg::*;

  localparam int DEPTH     = 16;
  localparam int MAX_CYCLE = 2000000;

  typedef struct packed {
    logic [1:0]  err;
    logic        full;
    logic        empty;
    logic [31:0] elem;
    logic [31:0] y;
    logic [31:0] x;
  } result_t;

  class transform_scoreboard;
    logic [31:0] stk [DEPTH*9];
    int unsigned level;
    logic [31:0] saved [9];
    logic [31:0] inv [9];
    result_t pending [$];
    int errors;

    function new();
      level = 0;
      errors = 0;
      foreach (saved[i]) saved[i] = '0;
      foreach (inv[i]) inv[i] = '0;
      foreach (stk[i]) stk[i] = '0;
    endfunction

    function void set_ident(int base);
      for (int i = 0; i < 9; i++) stk[base+i] = (i % 4 == 0) ? 32'd1 : 32'd0;
    endfunction

    function void map(input logic [31:0] m [9], input logic [31:0] xv, yv,
                      output logic [31:0] rx, ry);
      rx = xv * m[0] + yv * m[3] + m[6];
      ry = xv * m[1] + yv * m[4] + m[7];
    endfunction

    function void note_input(op_t op, logic [31:0] xv, yv, logic [3:0] idx);
      result_t r;
      int t, n;
      logic [31:0] m [9];
      logic [31:0] a, b, c, d, e, f, det, t0, t1, tmp;
      int dx, dy;
      r = '0;
      t = (level - 1) * 9;
      if (op == OP_INIT) begin
        level = 1;
        set_ident(0);
      end else if (op == OP_PUSH) begin
        if (level >= DEPTH) r.err = ERR_OVERFLOW;
        else begin
          level++;
          set_ident((level - 1) * 9);
        end
      end else if (op == OP_INV_POINT) begin
        map(inv, xv, yv, r.x, r.y);
      end else if (op <= OP_WRITE) begin
        if (level == 0 || (op == OP_PREMULT && level < 2)) r.err = ERR_UNDERFLOW;
        else begin
          case (op)
            OP_POP: level--;
            OP_IDENTITY: set_ident(t);
            OP_TRANSLATE: begin
              stk[t+6] += xv;
              stk[t+7] += yv;
            end
            OP_MIRROR_Y: begin
              stk[t+1] = -stk[t+1]; stk[t+4] = -stk[t+4]; stk[t+7] = -stk[t+7];
            end
            OP_MIRROR_X: begin
              stk[t+0] = -stk[t+0]; stk[t+3] = -stk[t+3]; stk[t+6] = -stk[t+6];
            end
            OP_ROTATE: begin
              dx = (xv == 0) ? 0 : (xv == 1) ? 1 : (xv == '1) ? -1 : 2;
              dy = (yv == 0) ? 0 : (yv == 1) ? 1 : (yv == '1) ? -1 : 2;
              if (dx == 0 && yv != 0) dy = yv[31] ? -1 : 1;
              else if (dy == 0 && xv != 0) dx = xv[31] ? -1 : 1;
              for (int rr = 0; rr < 3; rr++) begin
                n = t + rr * 3;
                if (dx == 0 && dy == -1) begin
                  tmp = stk[n]; stk[n] = stk[n+1]; stk[n+1] = -tmp;
                end else if (dx == 0 && dy == 1) begin
                  tmp = stk[n]; stk[n] = -stk[n+1]; stk[n+1] = tmp;
                end else if (dx == -1 && dy == 0) begin
                  stk[n] = -stk[n]; stk[n+1] = -stk[n+1];
                end
              end
            end
            OP_PREMULT: begin
              n = t - 9;
              for (int i = 0; i < 9; i++) m[i] = stk[t+i];
              for (int rr = 0; rr < 3; rr++) begin
                stk[t+rr*3] = m[rr*3] * stk[n] + m[rr*3+1] * stk[n+3]
                              + ((rr == 2) ? stk[n+6] : 32'd0);
                stk[t+rr*3+1] = m[rr*3] * stk[n+1] + m[rr*3+1] * stk[n+4]
                                + ((rr == 2) ? stk[n+7] : 32'd0);
              end
            end
            OP_POINT: begin
              for (int i = 0; i < 9; i++) m[i] = stk[t+i];
              map(m, xv, yv, r.x, r.y);
            end
            OP_INVERSE: begin
              a = stk[t]; b = stk[t+1]; c = stk[t+3]; d = stk[t+4];
              e = stk[t+6]; f = stk[t+7];
              det = a * d - c * b;
              t0 = c * f - e * d;
              t1 = b * e - a * f;
              if (det == 1) begin
                inv[0] = d; inv[1] = -b; inv[3] = -c; inv[4] = a;
                inv[6] = t0; inv[7] = t1;
              end else begin
                inv[0] = -d; inv[1] = b; inv[3] = c; inv[4] = -a;
                inv[6] = -t0; inv[7] = -t1;
              end
              inv[2] = 0; inv[5] = 0; inv[8] = 1;
            end
            OP_SAVE: for (int i = 0; i < 9; i++) saved[i] = stk[t+i];
            OP_RESTORE: for (int i = 0; i < 9; i++) stk[t+i] = saved[i];
            OP_LOAD_INV: for (int i = 0; i < 9; i++) stk[t+i] = inv[i];
            OP_READ: if (idx < 9) r.elem = stk[t+idx];
            OP_WRITE: if (idx < 9) stk[t+idx] = xv;
            default: ;
          endcase
        end
      end
      r.empty = (level == 0);
      r.full = (level >= DEPTH);
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.x !== w.x) begin
        $error("x_result exp %h got %h", w.x, got.x); errors++;
      end
      if (got.y !== w.y) begin
        $error("y_result exp %h got %h", w.y, got.y); errors++;
      end
      if (got.elem !== w.elem) begin
        $error("element_value exp %h got %h", w.elem, got.elem); errors++;
      end
      if (got.empty !== w.empty) begin
        $error("stack_empty exp %b got %b", w.empty, got.empty); errors++;
      end
      if (got.full !== w.full) begin
        $error("stack_full exp %b got %b", w.full, got.full); errors++;
      end
      if (got.err !== w.err) begin
        $error("error_code exp %0d got %0d", w.err, got.err); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [71:0] in_tdata;
  logic [4:0] in_tuser;
  logic [103:0] out_tdata;
  transform_scoreboard sb;
  int cycles;
  bit hold_off;
  bit sent_all;

  manhattan_transform_stack dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(op_t op, logic [31:0] xv, logic [31:0] yv, logic [3:0] idx,
                           bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'd0, idx, yv, xv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, xv, yv, idx);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic send_raw(logic [4:0] opc, logic [31:0] xv, logic [31:0] yv,
                          logic [3:0] idx);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= opc;
    in_tdata <= {4'd0, idx, yv, xv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op_t'(opc), xv, yv, idx);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20) - 10;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return '1;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return '1;
      3: return $urandom_range(2, 100);
      4: return -$urandom_range(2, 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("tb_manhattan_transform_stack NOT OK");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(result_t'(out_tdata[99:0]));

  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else begin
        g = gap_len();
        if (g == 0 || sent_all) out_tready <= 1'b1;
        else begin
          out_tready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    int depth_now;
    op_t op;
    cycles = 0;
    hold_off = 0;
    sent_all = 0;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty stack errors, extremes, every command
    send_word(OP_POP, 0, 0, 0, 0);
    send_word(OP_TRANSLATE, 5, 5, 0, 0);
    send_word(OP_INV_POINT, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send_word(OP_INIT, 0, 0, 0, 0);
    send_word(OP_PREMULT, 0, 0, 0, 0);
    send_word(OP_TRANSLATE, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send_word(OP_TRANSLATE, 1, '1, 0, 0);
    send_word(OP_ROTATE, 0, 32'h8000_0000, 0, 0);
    send_word(OP_ROTATE, 7, 0, 0, 0);
    send_word(OP_ROTATE, 3, 4, 0, 0);
    send_word(OP_MIRROR_Y, 0, 0, 0, 0);
    send_word(OP_MIRROR_X, 0, 0, 0, 0);
    send_word(OP_POINT, '1, 32'h7fff_ffff, 0, 0);
    send_word(OP_INVERSE, 0, 0, 0, 0);
    send_word(OP_SAVE, 0, 0, 0, 0);
    send_word(OP_PUSH, 0, 0, 0, 0);
    send_word(OP_WRITE, 32'hdead_beef, 0, 4'd8, 0);
    send_word(OP_WRITE, 32'h1234_5678, 0, 4'd15, 0);
    send_word(OP_READ, 0, 0, 4'd8, 0);
    send_word(OP_READ, 0, 0, 4'd15, 0);
    send_word(OP_PREMULT, 0, 0, 0, 0);
    send_word(OP_RESTORE, 0, 0, 0, 0);
    send_word(OP_LOAD_INV, 0, 0, 0, 0);
    send_word(OP_INV_POINT, 3, 9, 0, 0);
    send_raw(5'd31, '1, '1, 4'hf);
    send_word(OP_IDENTITY, 0, 0, 0, 0);

    // fill to overflow while the receiver holds off
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      repeat (DEPTH + 2) send_word(OP_PUSH, 0, 0, 0, 0);
    join
    wait_drained();
    while (sb.level > 0) send_word(OP_POP, 0, 0, 0, 1);
    send_word(OP_POP, 0, 0, 0, 0);
    wait_drained();

    // random: mostly well-formed sequences on a live stack
    for (int n = 0; n < 1230; n++) begin
      depth_now = sb.level;
      if (depth_now == 0 && $urandom_range(0, 9) != 0) op = OP_INIT;
      else if ($urandom_range(0, 60) == 0) op = OP_INIT;
      else if ($urandom_range(0, 7) == 0)
        op = (depth_now < 4 || $urandom_range(0, 2) == 0) ? OP_PUSH : OP_POP;
      else op = op_t'($urandom_range(2, 16));
      if ($urandom_range(0, 80) == 0) send_raw(5'($urandom_range(17, 31)), $urandom,
                                               $urandom, 4'($urandom));
      else if (op == OP_ROTATE) send_word(op, rand_dir(), rand_dir(), 0, 1);
      else if (op == OP_READ || op == OP_WRITE)
        send_word(op, rand_val(), $urandom, 4'($urandom_range(0, 15)), 1);
      else send_word(op, rand_val(), rand_val(), 4'($urandom), 1);
      if (n == 600) wait_drained();
    end
    sent_all = 1;
    wait_drained();
    if (sb.errors == 0) $display("tb_manhattan_transform_stack OK");
    else $display("tb_manhattan_transform_stack NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/mts_pkg.sv
rtl/mts_row_ram.sv
rtl/manhattan_transform_stack.sv
test/tb_manhattan_transform_stack.sv
